### src/ttkr_pkg.sv
// Package for the text-to-keyboard report block.
// Holds the queue entry type, the report phase enum and the character mapping functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttkr_pkg;

  localparam logic [7:0] MOD_NONE   = 8'h00;
  localparam logic [7:0] MOD_LSHIFT = 8'h02;
  localparam logic [7:0] MOD_RALT   = 8'h40;

  // Multi-byte words that map to accented keys.
  localparam logic [31:0] WORD_EURO   = 32'h00E2_82AC;
  localparam logic [31:0] WORD_POUND  = 32'h0000_C2A3;
  localparam logic [31:0] WORD_DEGREE = 32'h0000_C2B0;
  localparam logic [31:0] WORD_C_CED  = 32'h0000_C3A7;
  localparam logic [31:0] WORD_A_GRV  = 32'h0000_C3A0;
  localparam logic [31:0] WORD_E_GRV  = 32'h0000_C3A8;
  localparam logic [31:0] WORD_E_ACU  = 32'h0000_C3A9;
  localparam logic [31:0] WORD_I_GRV  = 32'h0000_C3AC;
  localparam logic [31:0] WORD_O_GRV  = 32'h0000_C3B2;
  localparam logic [31:0] WORD_U_GRV  = 32'h0000_C3B9;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_usage;
  } key_entry_t;

  typedef enum logic {
    PH_PRESS,
    PH_RELEASE
  } report_phase_t;

  function automatic key_entry_t make_entry(input logic [7:0] m, input logic [7:0] k);
    key_entry_t e;
    e.modifier_bits = m;
    e.key_usage     = k;
    return e;
  endfunction

  function automatic key_entry_t map_ascii(input logic [7:0] c);
    key_entry_t e;
    e = make_entry(MOD_NONE, 8'h00);
    if (c >= 8'h61 && c <= 8'h7A) begin
      e = make_entry(MOD_NONE, 8'(c - 8'h61) + 8'd4);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      e = make_entry(MOD_LSHIFT, 8'(c - 8'h41) + 8'd4);
    end else if (c == 8'h30) begin
      e = make_entry(MOD_NONE, 8'd39);
    end else if (c >= 8'h31 && c <= 8'h39) begin
      e = make_entry(MOD_NONE, 8'(c - 8'h31) + 8'd30);
    end else begin
      unique case (c)
        8'h2F: e = make_entry(MOD_LSHIFT, 8'h24);
        8'h08: e = make_entry(MOD_NONE,   8'h2A);
        8'h2D: e = make_entry(MOD_NONE,   8'h38);
        8'h09: e = make_entry(MOD_NONE,   8'h2B);
        8'h20: e = make_entry(MOD_NONE,   8'h2C);
        8'h2E: e = make_entry(MOD_NONE,   8'h37);
        8'h2C: e = make_entry(MOD_NONE,   8'h36);
        8'h3A: e = make_entry(MOD_LSHIFT, 8'h37);
        8'h3B: e = make_entry(MOD_LSHIFT, 8'h36);
        8'h27: e = make_entry(MOD_NONE,   8'h2D);
        8'h22: e = make_entry(MOD_LSHIFT, 8'h1F);
        8'h0A: e = make_entry(MOD_NONE,   8'h28);
        8'h5C: e = make_entry(MOD_NONE,   8'h35);
        8'h7C: e = make_entry(MOD_LSHIFT, 8'h35);
        8'h3D: e = make_entry(MOD_LSHIFT, 8'h27);
        8'h3F: e = make_entry(MOD_LSHIFT, 8'h2D);
        8'h3C: e = make_entry(MOD_NONE,   8'h64);
        8'h3E: e = make_entry(MOD_LSHIFT, 8'h64);
        8'h40: e = make_entry(MOD_RALT,   8'h33);
        8'h21: e = make_entry(MOD_LSHIFT, 8'h1E);
        8'h23: e = make_entry(MOD_RALT,   8'h34);
        8'h24: e = make_entry(MOD_LSHIFT, 8'h21);
        8'h25: e = make_entry(MOD_LSHIFT, 8'h22);
        8'h5E: e = make_entry(MOD_LSHIFT, 8'h2E);
        8'h26: e = make_entry(MOD_LSHIFT, 8'h23);
        8'h2A: e = make_entry(MOD_LSHIFT, 8'h30);
        8'h28: e = make_entry(MOD_LSHIFT, 8'h25);
        8'h29: e = make_entry(MOD_LSHIFT, 8'h26);
        8'h5F: e = make_entry(MOD_LSHIFT, 8'h38);
        8'h2B: e = make_entry(MOD_NONE,   8'h30);
        8'h5B: e = make_entry(MOD_RALT,   8'h2F);
        8'h5D: e = make_entry(MOD_RALT,   8'h30);
        8'h7B: e = make_entry(MOD_RALT,   8'h24);
        8'h7D: e = make_entry(MOD_RALT,   8'h27);
        default: e = make_entry(MOD_NONE, 8'h00);
      endcase
    end
    return e;
  endfunction

  function automatic key_entry_t map_word(input logic [31:0] w);
    key_entry_t e;
    unique case (w)
      WORD_EURO:   e = make_entry(MOD_RALT,   8'h08);
      WORD_POUND:  e = make_entry(MOD_LSHIFT, 8'h20);
      WORD_DEGREE: e = make_entry(MOD_LSHIFT, 8'h34);
      WORD_C_CED:  e = make_entry(MOD_LSHIFT, 8'h33);
      WORD_A_GRV:  e = make_entry(MOD_NONE,   8'h34);
      WORD_E_GRV:  e = make_entry(MOD_NONE,   8'h2F);
      WORD_E_ACU:  e = make_entry(MOD_LSHIFT, 8'h2F);
      WORD_I_GRV:  e = make_entry(MOD_NONE,   8'h2E);
      WORD_O_GRV:  e = make_entry(MOD_NONE,   8'h33);
      WORD_U_GRV:  e = make_entry(MOD_NONE,   8'h31);
      default:     e = make_entry(MOD_NONE,   8'h00);
    endcase
    return e;
  endfunction

  // Number of bytes still to come after a lead byte with the top bit set.
  function automatic logic [1:0] follow_count(input logic [7:0] b);
    logic [1:0] n;
    priority if ((b & 8'hE0) == 8'hC0) n = 2'd1;
    else if ((b & 8'hF0) == 8'hE0)     n = 2'd2;
    else if ((b & 8'hF8) == 8'hF0)     n = 2'd3;
    else                               n = 2'd0;
    return n;
  endfunction

endpackage

`default_nettype wire

### src/text_to_keyboard_report_top.sv
// Text to keyboard report converter, top level.
// Uses text bytes (ASCII or multi-byte sequences) and emits press/release report words.
// A byte enters on the in_ channel (in_valid, in_stall, in_text_byte). A byte that
// finishes a character yields two words on the out_ channel: a press word with the
// modifier and usage, then a release word with zeros and out_last_of_run set. Bytes
// that only extend an open sequence yield nothing. cfg_wr_en writes cfg_wr_data to
// the connection identifier, copied into out_link_id of every word; write it only
// while the block is idle.
// Path: the entry of a finishing byte passes through the queue and then the output
// register, where it becomes the press word; the release word follows it in the output
// register once the receiver has taken the press word.
// Throughput: the output register sends one word a cycle when the receiver does not
// stall, and a finishing byte needs two words; a continuation byte needs none. A queue
// of QUEUE_DEPTH entries lets the front take bytes while the back is still sending.
// When the receiver stalls the output word holds, the queue fills and in_stall rises.
// Reset (rst_n low, synchronous) closes any open sequence, empties the queue,
// drops out_valid and clears the connection identifier.
// Depends on ttkr_pkg, ttkr_fifo, ttkr_front and ttkr_back.
`timescale 1ns / 1ps
`default_nettype none

module text_to_keyboard_report_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_text_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_modifier_bits,
  output logic [7:0]  out_key_usage,
  output logic        out_key_count,
  output logic [15:0] out_link_id,
  output logic        out_last_of_run
);
  import ttkr_pkg::*;

  logic [15:0] conn_id_r;
  logic        push, q_full, q_pop, q_empty;
  key_entry_t  push_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_id_r <= '0;
    end else if (cfg_wr_en) begin
      conn_id_r <= cfg_wr_data;
    end
  end

  ttkr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  ttkr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (q_head),
    .empty      (q_empty)
  );

  ttkr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .conn_id           (conn_id_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_modifier_bits (out_modifier_bits),
    .out_key_usage     (out_key_usage),
    .out_key_count     (out_key_count),
    .out_link_id       (out_link_id),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

### src/ttkr_fifo.sv
// Small register queue of key entries between the front and back parts.
// Depends on ttkr_pkg for key_entry_t.
`timescale 1ns / 1ps
`default_nettype none

module ttkr_fifo #(
  parameter int DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  ttkr_pkg::key_entry_t   push_entry,
  output logic                   full,
  input  wire                    pop,
  output ttkr_pkg::key_entry_t   head_entry,
  output logic                   empty
);
  import ttkr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  key_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### src/ttkr_front.sv
// Front part: accepts text bytes, joins multi-byte sequences and maps each
// finished character to a key entry. Depends on ttkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttkr_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [7:0]             in_text_byte,
  output logic                   push,
  output ttkr_pkg::key_entry_t   push_entry,
  input  wire                    q_full
);
  import ttkr_pkg::*;

  logic [1:0]  remain_r, remain_nxt;
  logic [31:0] word_r, word_nxt;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    remain_nxt = remain_r;
    word_nxt   = word_r;
    push       = 1'b0;
    push_entry = make_entry(MOD_NONE, 8'h00);
    if (accept) begin
      if (remain_r != 2'd0) begin
        // Inside a sequence every byte is joined, whatever its value.
        word_nxt   = {word_r[23:0], in_text_byte};
        remain_nxt = 2'(remain_r - 1'b1);
        push       = (remain_nxt == 2'd0);
        push_entry = map_word(word_nxt);
      end else if (!in_text_byte[7]) begin
        push       = 1'b1;
        push_entry = map_ascii(in_text_byte);
      end else begin
        word_nxt   = {24'h0, in_text_byte};
        remain_nxt = follow_count(in_text_byte);
        push       = (remain_nxt == 2'd0);
        push_entry = map_word(word_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= 2'd0;
      word_r   <= '0;
    end else begin
      remain_r <= remain_nxt;
      word_r   <= word_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ttkr_back.sv
// Back part: takes key entries from the queue and sends a press word
// followed by a release word through an output register. Depends on ttkr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttkr_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_empty,
  input  ttkr_pkg::key_entry_t   q_head,
  output logic                   q_pop,
  input  wire  [15:0]            conn_id,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [7:0]             out_modifier_bits,
  output logic [7:0]             out_key_usage,
  output logic                   out_key_count,
  output logic [15:0]            out_link_id,
  output logic                   out_last_of_run
);
  import ttkr_pkg::*;

  report_phase_t phase_r, phase_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    mod_r, key_r;
  logic          count_r, last_r;
  logic [15:0]   link_r;
  logic          load, send_rel;

  // The output register can take a new word when empty or being taken.
  assign load = !valid_r || !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_PRESS:   if (load && !q_empty) phase_nxt = PH_RELEASE;
      PH_RELEASE: if (load) phase_nxt = PH_PRESS;
      default:    phase_nxt = PH_PRESS;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    send_rel = 1'b0;
    unique case (phase_r)
      PH_PRESS:   q_pop    = load && !q_empty;
      PH_RELEASE: send_rel = load;
      default: begin
        q_pop    = 1'b0;
        send_rel = 1'b0;
      end
    endcase
    valid_nxt = load ? (q_pop || send_rel) : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRESS;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mod_r   <= q_head.modifier_bits;
      key_r   <= q_head.key_usage;
      count_r <= 1'b1;
      last_r  <= 1'b0;
      link_r  <= conn_id;
    end else if (send_rel) begin
      mod_r   <= MOD_NONE;
      key_r   <= 8'h00;
      count_r <= 1'b0;
      last_r  <= 1'b1;
      link_r  <= conn_id;
    end
  end

  assign out_valid         = valid_r;
  assign out_modifier_bits = mod_r;
  assign out_key_usage     = key_r;
  assign out_key_count     = count_r;
  assign out_link_id       = link_r;
  assign out_last_of_run   = last_r;

endmodule

`default_nettype wire
